>>> hdl/pps_pkg.sv
// Package for the pick-and-place sequencer: field widths, phase codes,
// register indexes and reset values for all sequencer modules but pps_skid.
// No dependencies.
package pps_pkg;

    localparam int ANGLE_W       = 15;
    localparam int DIST_W        = 16;
    localparam int TOL_W         = 12;
    localparam int ARM_JOINTS_DEF = 4;
    localparam int FINGERS_DEF    = 3;
    localparam int ARM_JOINTS_MAX = 8;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_GRASP   = 3'd1,
        PH_DROP    = 3'd2,
        PH_RELEASE = 3'd3,
        PH_HOME    = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   holding;
    } status_t;

    // Register indexes on the configuration port.
    localparam int REG_GRAB_THRESHOLD     = 0;
    localparam int REG_POSITION_TOLERANCE = 1;
    localparam int REG_RAMP_STEP          = 2;
    localparam int REG_GRIP_TARGET        = 3;
    localparam int REG_DROP_BASE          = 4;

    localparam logic [DIST_W-1:0]         GRAB_THRESHOLD_RST = 16'd350;
    localparam logic [TOL_W-1:0]          TOLERANCE_RST      = 12'd82;
    localparam logic [TOL_W-1:0]          RAMP_STEP_RST      = 12'd131;
    localparam logic signed [ANGLE_W-1:0] GRIP_TARGET_RST    = 15'sd3482;
    localparam logic signed [ANGLE_W-1:0] RELEASE_TARGET     = 15'sd205;
    localparam logic signed [ANGLE_W-1:0] HOME_ANGLE         = 15'sd0;

    function automatic logic signed [ANGLE_W-1:0] drop_reset(input int idx);
        logic signed [ANGLE_W-1:0] val;
        case (idx)
            0:       val = -15'sd7700;
            1:       val = -15'sd8765;
            2:       val = -15'sd9748;
            3:       val = -15'sd6185;
            default: val = 15'sd0;
        endcase
        return val;
    endfunction

endpackage

>>> hdl/pps_lane.sv
// One joint or finger lane of the pick-and-place sequencer: reach check
// against a target and the rate-limited set-point step. Uses pps_pkg.
module pps_lane (
    input  logic signed [pps_pkg::ANGLE_W-1:0] pos,
    input  logic signed [pps_pkg::ANGLE_W-1:0] target,
    input  logic        [pps_pkg::TOL_W-1:0]   tolerance,
    input  logic        [pps_pkg::TOL_W-1:0]   step,
    output logic                               reached,
    output logic signed [pps_pkg::ANGLE_W-1:0] ramp_cmd
);

    localparam int W = pps_pkg::ANGLE_W + 1;

    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] tgt_x;
    logic signed [W-1:0] err;
    logic        [W-1:0] mag;
    logic signed [W-1:0] step_x;
    logic signed [W-1:0] clamped;
    logic signed [W-1:0] sum;

    assign pos_x  = {pos[pps_pkg::ANGLE_W-1], pos};
    assign tgt_x  = {target[pps_pkg::ANGLE_W-1], target};
    assign err    = tgt_x - pos_x;
    assign mag    = err[W-1] ? W'(-err) : W'(err);
    assign step_x = signed'({{(W - pps_pkg::TOL_W){1'b0}}, step});

    assign reached = (mag <= {{(W - pps_pkg::TOL_W){1'b0}}, tolerance});

    always_comb
    begin
        if (err > step_x)
            clamped = step_x;
        else if (err < -step_x)
            clamped = -step_x;
        else
            clamped = err;
    end

    // The result lies between the position and the target, so it fits.
    assign sum      = pos_x + clamped;
    assign ramp_cmd = sum[pps_pkg::ANGLE_W-1:0];

endmodule

>>> hdl/pps_ctrl.sv
// Phase sequencer of the pick-and-place block: merges the lane reach flags,
// steps the five-phase state machine and holds the set-points. Uses pps_pkg.
module pps_ctrl #(
    parameter int ARM_JOINTS = pps_pkg::ARM_JOINTS_DEF,
    parameter int FINGERS    = pps_pkg::FINGERS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       accept,
    input  logic [pps_pkg::DIST_W-1:0]                 distance,
    input  logic [pps_pkg::DIST_W-1:0]                 grab_threshold,
    input  logic signed [pps_pkg::ANGLE_W-1:0]         grip_target,
    input  logic [FINGERS-1:0]                         finger_reached,
    input  logic [ARM_JOINTS-1:0]                      arm_reached,
    input  logic [ARM_JOINTS-1:0][pps_pkg::ANGLE_W-1:0] arm_ramp,
    output pps_pkg::phase_t                            phase_cur,
    output pps_pkg::status_t                           status_next,
    output logic [pps_pkg::ANGLE_W-1:0]                finger_cmd_next,
    output logic [ARM_JOINTS-1:0][pps_pkg::ANGLE_W-1:0] arm_cmd_next
);

    pps_pkg::phase_t phase_reg;
    pps_pkg::phase_t phase_next;
    logic            holding_reg;
    logic            holding_next;
    logic [pps_pkg::ANGLE_W-1:0] finger_target_reg;
    logic [pps_pkg::ANGLE_W-1:0] finger_target_next;
    logic [ARM_JOINTS-1:0][pps_pkg::ANGLE_W-1:0] setpoint_reg;
    logic [ARM_JOINTS-1:0][pps_pkg::ANGLE_W-1:0] setpoint_next;
    logic            fingers_all;
    logic            arm_all;
    logic            arm_load;

    assign fingers_all = &finger_reached;
    assign arm_all     = &arm_reached;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            pps_pkg::PH_GRASP:
                if (fingers_all)
                    phase_next = pps_pkg::PH_DROP;
            pps_pkg::PH_DROP:
                if (arm_all)
                    phase_next = pps_pkg::PH_RELEASE;
            pps_pkg::PH_RELEASE:
                if (fingers_all)
                    phase_next = pps_pkg::PH_HOME;
            pps_pkg::PH_HOME:
                if (arm_all)
                    phase_next = pps_pkg::PH_WAIT;
            default:
                if (distance < grab_threshold)
                    phase_next = pps_pkg::PH_GRASP;
        endcase
    end

    always_comb
    begin
        holding_next       = holding_reg;
        finger_target_next = finger_target_reg;
        arm_load           = 1'b0;
        case (phase_reg)
            pps_pkg::PH_GRASP:
                if (fingers_all)
                    holding_next = 1'b1;
            pps_pkg::PH_DROP:
            begin
                arm_load = 1'b1;
                if (arm_all)
                    finger_target_next = pps_pkg::RELEASE_TARGET;
            end
            pps_pkg::PH_RELEASE:
                if (fingers_all)
                    holding_next = 1'b0;
            pps_pkg::PH_HOME:
                arm_load = 1'b1;
            default:
                if (distance < grab_threshold)
                    finger_target_next = grip_target;
        endcase
    end

    assign setpoint_next = arm_load ? arm_ramp : setpoint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= pps_pkg::PH_WAIT;
            holding_reg       <= 1'b0;
            finger_target_reg <= pps_pkg::RELEASE_TARGET;
            setpoint_reg      <= {ARM_JOINTS{pps_pkg::HOME_ANGLE}};
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            holding_reg       <= holding_next;
            finger_target_reg <= finger_target_next;
            setpoint_reg      <= setpoint_next;
        end
    end

    // The result reflects the state after this request's update.
    assign phase_cur           = phase_reg;
    assign status_next.phase   = phase_next;
    assign status_next.holding = holding_next;
    assign finger_cmd_next     = finger_target_next;
    assign arm_cmd_next        = setpoint_next;

`ifndef SYNTH
    a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
        holding_reg |-> (phase_reg == pps_pkg::PH_DROP || phase_reg == pps_pkg::PH_RELEASE))
        else $error("holding flag set outside drop and release phases");
    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(setpoint_reg)))
        else $error("sequencer state changed without a request");
    a_open_release: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pps_pkg::PH_RELEASE) |-> (finger_target_reg == pps_pkg::RELEASE_TARGET))
        else $error("fingers not commanded open during release");
`endif

endmodule

>>> hdl/pps_skid.sv
// Output register with a skid stage for the pick-and-place sequencer result
// channel, so a new request is taken while a result waits. No dependencies.
module pps_skid #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             take;

    assign in_ready  = !skid_valid_reg;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= take;
        end
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (take)
                out_data_reg <= in_data;
        end
        else if (take)
            skid_data_reg <= in_data;
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled without a stalled output");
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !out_ready) |=> $stable(skid_data_reg))
        else $error("skid entry changed while output stalled");
`endif

endmodule

>>> hdl/pick_place_sequencer.sv
// Top level of the pick-and-place sequencer: configuration registers, the
// finger and arm lanes, the phase sequencer and the result skid stage.
// Depends on pps_pkg, pps_lane, pps_ctrl and pps_skid.
//
// Usage: each request on the s_ channel is one sensor tick (distance, finger
// positions, arm joint positions). For every request exactly one result
// leaves on the m_ channel: finger set-point, arm set-points, phase and the
// holding flag, all reflecting the state after that tick.
// Each result is registered. Throughput is one request per cycle while
// s_tready is high; the limit is the loop through the lanes and the phase
// state register in pps_ctrl. Registers must be written over the APB port
// only while no request is in flight; the block does not enforce this.
// Reset puts the sequence in the wait phase with fingers open (205) and the
// arm at home (all zero), loads register defaults and empties the output.
// When the receiver stalls, one more result is kept in the skid stage;
// s_tready then drops until the receiver takes a result.
module pick_place_sequencer #(
    parameter int ARM_JOINTS = pps_pkg::ARM_JOINTS_DEF,
    parameter int FINGERS    = pps_pkg::FINGERS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata, from bit 0: distance, finger_pos_a.., arm_pos_a.., zero fill
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [pps_pkg::DIST_W + pps_pkg::ANGLE_W * (FINGERS + ARM_JOINTS) + 7 -
                  ((pps_pkg::DIST_W + pps_pkg::ANGLE_W * (FINGERS + ARM_JOINTS) + 7) % 8)
                  - 1:0]  s_tdata,
    // m_tdata, from bit 0: finger_cmd, arm_cmd_a.., phase, holding, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [pps_pkg::ANGLE_W * (1 + ARM_JOINTS) + 4 + 7 -
                  ((pps_pkg::ANGLE_W * (1 + ARM_JOINTS) + 4 + 7) % 8) - 1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [$clog2(4 * (4 + ARM_JOINTS))-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW       = pps_pkg::ANGLE_W;
    localparam int NUM_REGS = pps_pkg::REG_DROP_BASE + ARM_JOINTS;
    localparam int PA_W     = $clog2(4 * NUM_REGS);
    localparam int IDX_W    = PA_W - 2;
    localparam int IN_BITS  = pps_pkg::DIST_W + AW * (FINGERS + ARM_JOINTS);
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_BITS = AW * (1 + ARM_JOINTS) + 4;
    localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;
    localparam int ARM_OFS  = pps_pkg::DIST_W + AW * FINGERS;

    logic [pps_pkg::DIST_W-1:0]          grab_threshold_reg;
    logic [pps_pkg::TOL_W-1:0]           tolerance_reg;
    logic [pps_pkg::TOL_W-1:0]           ramp_step_reg;
    logic signed [AW-1:0]                grip_target_reg;
    logic [ARM_JOINTS-1:0][AW-1:0]       drop_reg;

    logic [IDX_W-1:0]                    cfg_idx;
    logic                                cfg_write;

    pps_pkg::phase_t                     phase_cur;
    pps_pkg::status_t                    status_next;
    logic [AW-1:0]                       finger_cmd_next;
    logic [ARM_JOINTS-1:0][AW-1:0]       arm_cmd_next;
    logic [FINGERS-1:0]                  finger_reached;
    logic [ARM_JOINTS-1:0]               arm_reached;
    logic [ARM_JOINTS-1:0][AW-1:0]       arm_ramp;
    logic signed [AW-1:0]                finger_goal;
    logic                                accept;
    logic [OUT_W-1:0]                    result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PA_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grab_threshold_reg <= pps_pkg::GRAB_THRESHOLD_RST;
            tolerance_reg      <= pps_pkg::TOLERANCE_RST;
            ramp_step_reg      <= pps_pkg::RAMP_STEP_RST;
            grip_target_reg    <= pps_pkg::GRIP_TARGET_RST;
            for (int j = 0; j < ARM_JOINTS; j++)
                drop_reg[j] <= pps_pkg::drop_reset(j);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                IDX_W'(pps_pkg::REG_GRAB_THRESHOLD):
                    grab_threshold_reg <= pwdata[pps_pkg::DIST_W-1:0];
                IDX_W'(pps_pkg::REG_POSITION_TOLERANCE):
                    tolerance_reg <= pwdata[pps_pkg::TOL_W-1:0];
                IDX_W'(pps_pkg::REG_RAMP_STEP):
                    ramp_step_reg <= pwdata[pps_pkg::TOL_W-1:0];
                IDX_W'(pps_pkg::REG_GRIP_TARGET):
                    grip_target_reg <= pwdata[AW-1:0];
                default:
                    for (int j = 0; j < ARM_JOINTS; j++)
                        if (cfg_idx == IDX_W'(pps_pkg::REG_DROP_BASE + j))
                            drop_reg[j] <= pwdata[AW-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            IDX_W'(pps_pkg::REG_GRAB_THRESHOLD):
                prdata = 32'(grab_threshold_reg);
            IDX_W'(pps_pkg::REG_POSITION_TOLERANCE):
                prdata = 32'(tolerance_reg);
            IDX_W'(pps_pkg::REG_RAMP_STEP):
                prdata = 32'(ramp_step_reg);
            IDX_W'(pps_pkg::REG_GRIP_TARGET):
                prdata = 32'(grip_target_reg);
            default:
                for (int j = 0; j < ARM_JOINTS; j++)
                    if (cfg_idx == IDX_W'(pps_pkg::REG_DROP_BASE + j))
                        prdata = 32'(signed'(drop_reg[j]));
        endcase
    end

    // ---------------- lanes ----------------
    assign accept = s_tvalid && s_tready;

    // Grasp checks against the closed position, release against open.
    assign finger_goal = (phase_cur == pps_pkg::PH_RELEASE) ?
                         pps_pkg::RELEASE_TARGET : grip_target_reg;

    for (genvar f = 0; f < FINGERS; f++)
    begin : g_finger
        pps_lane u_lane (
            .pos       (s_tdata[pps_pkg::DIST_W + AW * f +: AW]),
            .target    (finger_goal),
            .tolerance (tolerance_reg),
            .step      (ramp_step_reg),
            .reached   (finger_reached[f]),
            .ramp_cmd  ()
        );
    end

    for (genvar j = 0; j < ARM_JOINTS; j++)
    begin : g_arm
        logic signed [AW-1:0] arm_goal;

        assign arm_goal = (phase_cur == pps_pkg::PH_DROP) ?
                          signed'(drop_reg[j]) : pps_pkg::HOME_ANGLE;

        pps_lane u_lane (
            .pos       (s_tdata[ARM_OFS + AW * j +: AW]),
            .target    (arm_goal),
            .tolerance (tolerance_reg),
            .step      (ramp_step_reg),
            .reached   (arm_reached[j]),
            .ramp_cmd  (arm_ramp[j])
        );
    end

    // ---------------- sequencer ----------------
    pps_ctrl #(
        .ARM_JOINTS (ARM_JOINTS),
        .FINGERS    (FINGERS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .distance        (s_tdata[pps_pkg::DIST_W-1:0]),
        .grab_threshold  (grab_threshold_reg),
        .grip_target     (grip_target_reg),
        .finger_reached  (finger_reached),
        .arm_reached     (arm_reached),
        .arm_ramp        (arm_ramp),
        .phase_cur       (phase_cur),
        .status_next     (status_next),
        .finger_cmd_next (finger_cmd_next),
        .arm_cmd_next    (arm_cmd_next)
    );

    assign result = OUT_W'({status_next.holding, status_next.phase,
                            arm_cmd_next, finger_cmd_next});

    // ---------------- result channel ----------------
    pps_skid #(
        .WIDTH (OUT_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
